// File: sv/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");

`endif

// File: sv/dwpdsc_pkg.sv
// ----------------------------------------------------------------------------
// dwpdsc_pkg
// Types and constants shared by the dual-wheel PD speed controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dwpdsc_pkg;

  localparam int DIV_W = 36;

  localparam logic [35:0] RPM_NUM    = 36'd61440000000;
  localparam logic [11:0] RPM_DEN    = 12'd2249;
  localparam logic [23:0] RPM_Q8_MAX = 24'hFFFFFF;

  localparam logic [7:0] LEFT_LIMIT  = 8'd140;
  localparam logic [7:0] RIGHT_LIMIT = 8'd138;

  localparam logic [15:0] FIX_LKP = 16'd5082;
  localparam logic [15:0] FIX_LKD = 16'd277;
  localparam logic [15:0] FIX_RKP = 16'd4936;
  localparam logic [15:0] FIX_RKD = 16'd243;

  localparam logic signed [15:0] LSLOPE_RST = -16'sd11161;
  localparam logic signed [15:0] LOFF_RST   = -16'sd3948;
  localparam logic signed [15:0] RSLOPE_RST = 16'sd11276;
  localparam logic signed [15:0] ROFF_RST   = 16'sd3923;

  localparam logic signed [19:0] DRIVE_MAX = 20'sd400;
  localparam logic signed [19:0] DRIVE_MIN = -20'sd400;

  typedef enum logic [2:0] {
    REG_LKP    = 3'd0,
    REG_LKD    = 3'd1,
    REG_RKP    = 3'd2,
    REG_RKD    = 3'd3,
    REG_LSLOPE = 3'd4,
    REG_LOFF   = 3'd5,
    REG_RSLOPE = 3'd6,
    REG_ROFF   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_KP    = 2'd0,
    MUL_KD    = 2'd1,
    MUL_SLOPE = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic [15:0]        lkp;
    logic [15:0]        lkd;
    logic [15:0]        rkp;
    logic [15:0]        rkd;
    logic signed [15:0] lslope;
    logic signed [15:0] loff;
    logic signed [15:0] rslope;
    logic signed [15:0] roff;
  } cfg_t;

  typedef struct packed {
    logic    load_in;
    logic    div_start;
    logic    div_tgt;
    logic    store_rpm;
    logic    store_tgt;
    logic    err_load;
    logic    mul_go;
    mul_op_t mul_op;
    logic    acc_add;
    logic    clamp;
    logic    drive_fin;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: sv/dwpdsc_div.sv
// ----------------------------------------------------------------------------
// dwpdsc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpdsc_div import dwpdsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic [DIV_W-1:0]  quotient,
  output logic              done
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] den;
  logic [5:0]       cnt;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign trial    = {rem, quo[DIV_W-1]};
  assign diff     = trial - {1'b0, den};
  assign ge       = trial >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: sv/dwpdsc_dp.sv
// ----------------------------------------------------------------------------
// dwpdsc_dp
// Datapath: item registers, shared divider, shared multiplier, accumulator,
// per-wheel error history and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpdsc_dp import dwpdsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               wheel,
  input  logic signed [9:0]  commanded_drive,
  input  logic [23:0]        pulse_period_us,
  input  logic               use_fixed_gains,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [9:0]  drive_value,
  output logic [15:0]        measured_rpm,
  output logic               period_invalid
);

  logic               wheel_r;
  logic signed [9:0]  cmd_r;
  logic [23:0]        period_r;
  logic               fixed_r;

  logic [23:0]        rpm;
  logic               invalid;
  logic signed [31:0] target;
  logic signed [31:0] err_r;
  logic signed [32:0] derr;
  logic signed [49:0] prod_r;
  logic signed [51:0] acc;
  logic [27:0]        u_r;
  logic signed [31:0] last_l;
  logic signed [31:0] last_r;

  logic signed [15:0] slope;
  logic signed [15:0] offset;
  logic [15:0]        kp;
  logic [15:0]        kd;
  logic [7:0]         limit;
  logic signed [31:0] prev;

  always_comb begin
    slope  = wheel_r ? cfg.rslope : cfg.lslope;
    offset = wheel_r ? cfg.roff : cfg.loff;
    limit  = wheel_r ? RIGHT_LIMIT : LEFT_LIMIT;
    prev   = wheel_r ? last_r : last_l;
    if (wheel_r) begin
      kp = fixed_r ? FIX_RKP : cfg.rkp;
      kd = fixed_r ? FIX_RKD : cfg.rkd;
    end else begin
      kp = fixed_r ? FIX_LKP : cfg.lkp;
      kd = fixed_r ? FIX_LKD : cfg.lkd;
    end
  end

  // Divider operands: rpm conversion or inverse motor line.
  logic [DIV_W-1:0]   den_rpm;
  logic signed [19:0] tnum;
  logic [19:0]        tnum_mag;
  logic [15:0]        slope_mag;
  logic               tneg;
  logic [DIV_W-1:0]   div_a;
  logic [DIV_W-1:0]   div_b;
  logic [DIV_W-1:0]   quot;
  logic               div_done;

  assign den_rpm   = DIV_W'(period_r) * DIV_W'(RPM_DEN);
  assign tnum      = {{2{cmd_r[9]}}, cmd_r, 8'b0} - {{4{offset[15]}}, offset};
  assign tnum_mag  = tnum[19] ? 20'(-tnum) : 20'(tnum);
  assign slope_mag = slope[15] ? 16'(-slope) : 16'(slope);
  assign tneg      = tnum[19] ^ slope[15];
  assign div_a     = cmd.div_tgt ? {4'b0, tnum_mag, 12'b0} : RPM_NUM;
  assign div_b     = cmd.div_tgt ? {20'b0, slope_mag} : den_rpm;

  dwpdsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .quotient (quot),
    .done     (div_done)
  );

  // Error: left wheel is truncated toward zero to whole rpm.
  logic signed [31:0] e_raw;
  logic signed [31:0] e_neg;
  logic signed [31:0] e_trunc;
  logic signed [31:0] e_sel;

  assign e_raw   = target - $signed({8'b0, rpm});
  assign e_neg   = -e_raw;
  assign e_trunc = e_raw[31] ? -$signed({e_neg[31:8], 8'b0}) : $signed({e_raw[31:8], 8'b0});
  assign e_sel   = wheel_r ? e_raw : e_trunc;

  // Shared multiplier operands.
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;

  always_comb begin
    case (cmd.mul_op)
      MUL_KP: begin
        mul_a = {err_r[31], err_r};
        mul_b = $signed({1'b0, kp});
      end
      MUL_KD: begin
        mul_a = derr;
        mul_b = $signed({1'b0, kd});
      end
      MUL_SLOPE: begin
        mul_a = $signed({5'b0, u_r});
        mul_b = {slope[15], slope};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  logic [27:0]        lim_q20;
  logic signed [51:0] prod_x;
  logic signed [19:0] dsh;
  logic signed [19:0] dq;

  assign lim_q20 = {limit, 20'b0};
  assign prod_x  = {{2{prod_r[49]}}, prod_r};
  assign dsh     = acc[51:32];
  assign dq      = (acc[51] && (acc[31:0] != 32'd0)) ? dsh + 20'sd1 : dsh;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      wheel_r  <= wheel;
      cmd_r    <= commanded_drive;
      period_r <= pulse_period_us;
      fixed_r  <= use_fixed_gains;
    end
    if (cmd.store_rpm) begin
      if (period_r == 24'd0) begin
        rpm     <= '0;
        invalid <= 1'b1;
      end else begin
        rpm     <= (quot > DIV_W'(RPM_Q8_MAX)) ? RPM_Q8_MAX : quot[23:0];
        invalid <= 1'b0;
      end
    end
    if (cmd.store_tgt) begin
      if (slope == 16'sd0) begin
        target <= '0;
      end else begin
        target <= tneg ? -$signed(quot[31:0]) : $signed(quot[31:0]);
      end
    end
    if (cmd.err_load) begin
      err_r <= e_sel;
      derr  <= {e_sel[31], e_sel} - {prev[31], prev};
      acc   <= $signed({16'b0, rpm, 12'b0});
    end
    if (cmd.mul_go) begin
      prod_r <= mul_p;
    end
    if (cmd.acc_add) begin
      acc <= acc + prod_x;
    end
    if (cmd.clamp) begin
      if (acc[51] || acc == 52'sd0) begin
        u_r <= '0;
      end else if (acc >= $signed({24'b0, lim_q20})) begin
        u_r <= lim_q20;
      end else begin
        u_r <= acc[27:0];
      end
    end
    if (cmd.drive_fin) begin
      acc <= prod_x + $signed({{12{offset[15]}}, offset, 24'b0});
    end
    if (cmd.out_load) begin
      if (dq > DRIVE_MAX) begin
        drive_value <= DRIVE_MAX[9:0];
      end else if (dq < DRIVE_MIN) begin
        drive_value <= DRIVE_MIN[9:0];
      end else begin
        drive_value <= dq[9:0];
      end
      measured_rpm   <= rpm[23:8];
      period_invalid <= invalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_l    <= '0;
      last_r    <= '0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (wheel_r) begin
          last_r <= err_r;
        end else begin
          last_l <= err_r;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

// File: sv/dwpdsc_ctrl.sv
// ----------------------------------------------------------------------------
// dwpdsc_ctrl
// Sequencer that steps the datapath through one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module dwpdsc_ctrl import dwpdsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'h0001,
    S_RPM_GO   = 13'h0002,
    S_RPM_WAIT = 13'h0004,
    S_TGT_GO   = 13'h0008,
    S_TGT_WAIT = 13'h0010,
    S_ERR      = 13'h0020,
    S_MKP      = 13'h0040,
    S_MKD      = 13'h0080,
    S_SUM      = 13'h0100,
    S_CLAMP    = 13'h0200,
    S_MSL      = 13'h0400,
    S_DRV      = 13'h0800,
    S_OUT      = 13'h1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_RPM_GO;
        end
      end
      S_RPM_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_RPM_WAIT;
      end
      S_RPM_WAIT: begin
        if (sts.div_done) begin
          cmd.store_rpm = 1'b1;
          state_next    = S_TGT_GO;
        end
      end
      S_TGT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_tgt   = 1'b1;
        state_next    = S_TGT_WAIT;
      end
      S_TGT_WAIT: begin
        cmd.div_tgt = 1'b1;
        if (sts.div_done) begin
          cmd.store_tgt = 1'b1;
          state_next    = S_ERR;
        end
      end
      S_ERR: begin
        cmd.err_load = 1'b1;
        state_next   = S_MKP;
      end
      S_MKP: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = MUL_KP;
        state_next = S_MKD;
      end
      S_MKD: begin
        cmd.acc_add = 1'b1;
        cmd.mul_go  = 1'b1;
        cmd.mul_op  = MUL_KD;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.acc_add = 1'b1;
        state_next  = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_MSL;
      end
      S_MSL: begin
        cmd.mul_go = 1'b1;
        cmd.mul_op = MUL_SLOPE;
        state_next = S_DRV;
      end
      S_DRV: begin
        cmd.drive_fin = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/dual_wheel_pd_speed_controller.sv
// ----------------------------------------------------------------------------
// dual_wheel_pd_speed_controller
// PD speed controller for a left and a right wheel sharing one datapath.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                 Payload
// input     in_valid / in_ready       wheel, commanded_drive, pulse_period_us,
//                                     use_fixed_gains
// output    out_valid / out_ready     drive_value, measured_rpm, period_invalid
// config    psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// A transaction runs the shared 36-bit restoring divider twice (rpm
// conversion, then the inverse motor line) at one quotient bit per cycle,
// then the sequencer steps around the shared multiplier: error, Kp and Kd
// products, sum, clamp, slope product, drive and output.
// Reset clears the sequencer, the output valid flag and both wheels' last
// errors, and loads the configuration registers with their default values.
// A stalled output holds its result; the next input transaction is taken
// meanwhile and waits at its final step until the output register frees.
//
`default_nettype none

module dual_wheel_pd_speed_controller import dwpdsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               wheel,
  input  logic signed [9:0]  commanded_drive,
  input  logic [23:0]        pulse_period_us,
  input  logic               use_fixed_gains,
  // Output channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [9:0]  drive_value,
  output logic [15:0]        measured_rpm,
  output logic               period_invalid,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers. All eight are 16 bits wide and sit on a
  // four-byte stride, so the register index is address bits [4:2].
  cfg_t     cfg;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lkp    <= FIX_LKP;
      cfg.lkd    <= FIX_LKD;
      cfg.rkp    <= FIX_RKP;
      cfg.rkd    <= FIX_RKD;
      cfg.lslope <= LSLOPE_RST;
      cfg.loff   <= LOFF_RST;
      cfg.rslope <= RSLOPE_RST;
      cfg.roff   <= ROFF_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LKP:    cfg.lkp    <= pwdata[15:0];
        REG_LKD:    cfg.lkd    <= pwdata[15:0];
        REG_RKP:    cfg.rkp    <= pwdata[15:0];
        REG_RKD:    cfg.rkd    <= pwdata[15:0];
        REG_LSLOPE: cfg.lslope <= $signed(pwdata[15:0]);
        REG_LOFF:   cfg.loff   <= $signed(pwdata[15:0]);
        REG_RSLOPE: cfg.rslope <= $signed(pwdata[15:0]);
        REG_ROFF:   cfg.roff   <= $signed(pwdata[15:0]);
        default: begin
        end
      endcase
    end
  end

  // Read back returns the 16-bit register value in the low half.
  always_comb begin
    case (cfg_idx)
      REG_LKP:    prdata = {16'b0, cfg.lkp};
      REG_LKD:    prdata = {16'b0, cfg.lkd};
      REG_RKP:    prdata = {16'b0, cfg.rkp};
      REG_RKD:    prdata = {16'b0, cfg.rkd};
      REG_LSLOPE: prdata = {16'b0, cfg.lslope};
      REG_LOFF:   prdata = {16'b0, cfg.loff};
      REG_RSLOPE: prdata = {16'b0, cfg.rslope};
      REG_ROFF:   prdata = {16'b0, cfg.roff};
      default:    prdata = '0;
    endcase
  end

  // The sequencer drives the datapath through command and status structs.
  dp_cmd_t cmd;
  dp_sts_t sts;

  dwpdsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dwpdsc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .wheel           (wheel),
    .commanded_drive (commanded_drive),
    .pulse_period_us (pulse_period_us),
    .use_fixed_gains (use_fixed_gains),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .drive_value     (drive_value),
    .measured_rpm    (measured_rpm),
    .period_invalid  (period_invalid)
  );

endmodule

`default_nettype wire

// File: sv/dwpdsc_chk.sv
// ----------------------------------------------------------------------------
// dwpdsc_chk
// Port-level checks for the dual-wheel PD speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dwpdsc_chk (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [9:0] drive_value,
  input logic [15:0]       measured_rpm,
  input logic              period_invalid
);

  `ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(drive_value))
  `ASSERT_IMP(a_zero_rpm, clk, rst, out_valid && period_invalid, measured_rpm == 16'd0)
  `ASSERT_IMP(a_drive_rng, clk, rst, out_valid, (drive_value <= 10'sd400) && (drive_value >= -10'sd400))

endmodule

bind dual_wheel_pd_speed_controller dwpdsc_chk u_chk (.*);

`default_nettype wire
